// ===== rtl/outage_interval_tracker_top_macros.svh =====
// ---------------------------------------------------------------------------
// Outage interval tracker assertion macros
// Checks a consequent in the same cycle or in the next cycle.
// ---------------------------------------------------------------------------
`ifndef OUTAGE_INTERVAL_TRACKER_TOP_MACROS_SVH
`define OUTAGE_INTERVAL_TRACKER_TOP_MACROS_SVH

`ifndef SYNTH
`define OIT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define OIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OIT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define OIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/oit_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Outage interval tracker package
// Field widths, result kinds, table entry layout and sequencer states.
// ---------------------------------------------------------------------------
package oit_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int TS_W     = 47;
    localparam int ADDR_W   = 32;
    localparam int PREFIX_W = 6;
    localparam int KIND_W   = 2;

    localparam int IN_FIELDS_W  = TS_W + ADDR_W + PREFIX_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ADDR_W + PREFIX_W + TS_W + TS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLOSED   = 2'd0,
        KIND_OPEN     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        MODE_PROBE = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [PREFIX_W-1:0] prefix;
        logic [TS_W-1:0]     start;
    } entry_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [PREFIX_W-1:0] prefix;
        logic [TS_W-1:0]     start;
        logic [TS_W-1:0]     stop;
        logic                last;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_WAIT   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

endpackage

// ===== rtl/outage_interval_tracker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Outage interval tracker
// Table of open outages per host key, held in an entry memory with one read and one write port.
// ---------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_       in         probe record or flush request
//  m_       out        closed, still-open or table-full outage report
//
// A probe does one memory read per entry, the last compare in ST_WAIT, the decision
// in ST_DECIDE, then the report moves to the output register.
// A flush with n open entries does n full memory scans, one per reported entry, to
// find the next smallest key; an empty flush does one scan and reports nothing.
// Reset clears only the valid flags of the table, at once; there is no clearing pass.
// A report waits in the output register while m_tready is low; the next item
// is taken as soon as the sequencer is idle again.
`include "outage_interval_tracker_top_macros.svh"

module outage_interval_tracker_top
    import oit_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // timestamp [46:0], host_address [78:47], prefix_len [84:79], timed_out [85]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode [0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_address [31:0], out_prefix [37:32], start_time [84:38], end_time [131:85]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind [1:0]
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    // Item held for the whole pass.
    logic                in_mode_reg;
    logic [TS_W-1:0]     in_ts_reg;
    logic [ADDR_W-1:0]   in_addr_reg;
    logic [PREFIX_W-1:0] in_prefix_reg;
    logic                in_tout_reg;

    logic [ENTRIES-1:0]  valid_reg;
    entry_t              mem [ENTRIES];
    entry_t              rd_data_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;

    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [TS_W-1:0]     hit_start_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                best_found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    entry_t              best_ent_reg;
    logic [CNT_W-1:0]    cnt_reg;

    result_t             res_reg;
    logic                more_reg;

    logic                m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0]   m_tuser_reg;
    logic                m_tlast_reg;

    logic                accept;
    logic                start_scan;
    logic                out_load;
    logic                cur_valid;
    logic                key_eq;
    logic                key_lt;

    logic                dec_emit;
    logic                dec_more;
    result_t             dec_res;
    logic                dec_set;
    logic                dec_clr;
    logic [IDX_W-1:0]    dec_idx;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_load   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign start_scan = accept || (out_load && more_reg);

    assign cur_valid = valid_reg[pend_idx_reg];
    assign key_eq    = (rd_data_reg.addr == in_addr_reg) &&
                       (rd_data_reg.prefix == in_prefix_reg);
    assign key_lt    = {rd_data_reg.addr, rd_data_reg.prefix} <
                       {best_ent_reg.addr, best_ent_reg.prefix};

    // Outcome of a finished scan.
    always_comb begin
        dec_emit = 1'b0;
        dec_more = 1'b0;
        dec_set  = 1'b0;
        dec_clr  = 1'b0;
        dec_idx  = best_idx_reg;
        dec_res  = '{kind: KIND_OPEN, addr: best_ent_reg.addr, prefix: best_ent_reg.prefix,
                     start: best_ent_reg.start, stop: '0, last: (cnt_reg == CNT_W'(1))};
        if (in_mode_reg == MODE_FLUSH) begin
            if (cnt_reg != '0) begin
                dec_emit = 1'b1;
                dec_more = (cnt_reg != CNT_W'(1));
                dec_clr  = 1'b1;
            end
        end else if (in_tout_reg) begin
            if (!hit_found_reg) begin
                if (free_found_reg) begin
                    dec_set = 1'b1;
                    dec_idx = free_idx_reg;
                end else begin
                    dec_emit = 1'b1;
                    dec_res  = '{kind: KIND_OVERFLOW, addr: in_addr_reg, prefix: in_prefix_reg,
                                 start: in_ts_reg, stop: '0, last: 1'b1};
                end
            end
        end else if (hit_found_reg) begin
            dec_emit = 1'b1;
            dec_clr  = 1'b1;
            dec_idx  = hit_idx_reg;
            dec_res  = '{kind: KIND_CLOSED, addr: in_addr_reg, prefix: in_prefix_reg,
                         start: hit_start_reg, stop: in_ts_reg, last: 1'b1};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = dec_emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = more_reg ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);
            if (state_reg == ST_DECIDE) begin
                if (dec_set) begin
                    valid_reg[dec_idx] <= 1'b1;
                end
                if (dec_clr) begin
                    valid_reg[dec_idx] <= 1'b0;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Entry memory: one read per scan cycle, one write when an entry opens.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE && dec_set) begin
            mem[dec_idx] <= '{addr: in_addr_reg, prefix: in_prefix_reg, start: in_ts_reg};
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_mode_reg   <= s_tuser;
            in_ts_reg     <= s_tdata[TS_W-1:0];
            in_addr_reg   <= s_tdata[TS_W +: ADDR_W];
            in_prefix_reg <= s_tdata[TS_W + ADDR_W +: PREFIX_W];
            in_tout_reg   <= s_tdata[TS_W + ADDR_W + PREFIX_W];
        end

        pend_idx_reg <= scan_idx_reg;
        if (start_scan) begin
            scan_idx_reg <= '0;
        end else if (state_reg == ST_SCAN && scan_idx_reg != LAST_IDX) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end

        if (start_scan) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end else if (pend_reg) begin
            if (cur_valid) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!hit_found_reg && key_eq) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= pend_idx_reg;
                    hit_start_reg <= rd_data_reg.start;
                end
                // Strict compare keeps the lowest index on equal keys.
                if (!best_found_reg || key_lt) begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= pend_idx_reg;
                    best_ent_reg   <= rd_data_reg;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pend_idx_reg;
            end
        end

        if (state_reg == ST_DECIDE) begin
            res_reg  <= dec_res;
            more_reg <= dec_more;
        end

        if (out_load) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res_reg.stop, res_reg.start,
                            res_reg.prefix, res_reg.addr};
            m_tuser_reg <= res_reg.kind;
            m_tlast_reg <= res_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `OIT_ASSERT_NEXT(a_accept_scans, aclk, aresetn, accept, state_reg == ST_SCAN, "accepted item did not start a scan")
    `OIT_ASSERT_NOW(a_pend_in_scan, aclk, aresetn, pend_reg, (state_reg == ST_SCAN) || (state_reg == ST_WAIT), "memory read pending outside a scan")
    `OIT_ASSERT_NOW(a_count_matches, aclk, aresetn, state_reg == ST_DECIDE, int'(cnt_reg) == $countones(valid_reg), "scan count differs from open entries")
    `OIT_ASSERT_NEXT(a_flush_frees, aclk, aresetn, (state_reg == ST_DECIDE) && (in_mode_reg == MODE_FLUSH) && (cnt_reg != '0), !valid_reg[$past(best_idx_reg)], "flushed entry still open")

endmodule
